/* sv/triangle_face_normal_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the triangle face normal core
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_CORE_DEFINES_SVH

// Checked only outside reset.
`define TFN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define TFN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants of the triangle face normal core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfn_pkg;

  // The largest normalized magnitude has its leading one at bit MAG_BITS-1.
  localparam int MAG_BITS = 30;
  // Sum of three squared normalized magnitudes.
  localparam int SUM_BITS = 2 * MAG_BITS + 2;
  // Integer square root of the sum.
  localparam int ROOT_BITS = SUM_BITS / 2;
  // Width of each output component.
  localparam int OUT_BITS = 16;

  // Control information that travels with each transaction.
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tfn_side_t;

  localparam int SIDE_BITS = $bits(tfn_side_t);

endpackage

/* sv/triangle_face_normal_core.sv */
// The core returns the unit face normal of one triangle per transaction and
// accepts a new triangle in every clock cycle while the result side keeps up.
// An accepted input passes through the cross product, normalization and
// squaring, the digit-per-stage square root, the divider and one output
// register. The whole pipeline holds when a result waits unaccepted. A zero
// cross product gives a zero normal with tuser set.
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_face_normal_core #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]          s_tdata,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // nx, ny, nz from the lowest bit up
  output logic [3*tfn_pkg::OUT_BITS-1:0]             m_tdata,
  // degenerate
  output logic                                       m_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready
);
  import tfn_pkg::*;

  localparam int EDGE_BITS = (COORD_BITS > 28) ? 29 : COORD_BITS + 1;
  localparam int MW        = 2 * EDGE_BITS;
  localparam int QW        = NORMAL_FRAC_BITS + 2;
  localparam int PAY_BITS  = SIDE_BITS + 3 * MAG_BITS;

  logic                              en;
  logic [2:0][COORD_BITS-1:0]        pa, pb, pc;
  tfn_side_t                         sd_x, sd_n, sd_s, sd_d;
  logic [2:0][MW-1:0]                mag_x;
  logic [SUM_BITS-1:0]               sum;
  logic [2:0][MAG_BITS-1:0]          mag_n, mag_s;
  logic [ROOT_BITS-1:0]              root;
  logic [PAY_BITS-1:0]               pay_s;
  logic [2:0][NORMAL_FRAC_BITS:0]    quo;
  logic [2:0][OUT_BITS-1:0]          nrm_next;

  // The pipeline advances unless a result is held at the output.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign pa[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
    assign pb[i] = s_tdata[(3+i)*COORD_BITS +: COORD_BITS];
    assign pc[i] = s_tdata[(6+i)*COORD_BITS +: COORD_BITS];
  end

  tfn_cross #(.COORD_BITS(COORD_BITS), .EDGE_BITS(EDGE_BITS)) u_cross (
    .clk, .rst, .en, .in_valid(s_tvalid), .pa, .pb, .pc, .side(sd_x), .mag(mag_x)
  );

  tfn_norm #(.MW(MW)) u_norm (
    .clk, .rst, .en, .side_in(sd_x), .mag_in(mag_x),
    .side_out(sd_n), .sum, .mag_out(mag_n)
  );

  tfn_isqrt #(.PW(PAY_BITS)) u_isqrt (
    .clk, .rst, .en, .s(sum), .pay_in({sd_n, mag_n}), .root, .pay_out(pay_s)
  );

  assign sd_s  = pay_s[PAY_BITS-1 -: SIDE_BITS];
  assign mag_s = pay_s[3*MAG_BITS-1:0];

  tfn_div #(.FRAC(NORMAL_FRAC_BITS)) u_div (
    .clk, .rst, .en, .d(root), .m(mag_s), .side_in(sd_s), .q(quo), .side_out(sd_d)
  );

  // Clamp to one, apply the sign and fit into the output field.
  always_comb begin
    logic [NORMAL_FRAC_BITS:0] qc;
    logic [QW-1:0]             val;
    logic [QW+OUT_BITS-1:0]    ext;
    for (int i = 0; i < 3; i++) begin
      qc = quo[i];
      if (qc[NORMAL_FRAC_BITS] && (qc[NORMAL_FRAC_BITS-1:0] != '0)) begin
        qc = (NORMAL_FRAC_BITS+1)'(1) << NORMAL_FRAC_BITS;
      end
      val = sd_d.neg[i] ? QW'(-{1'b0, qc}) : {1'b0, qc};
      ext = {{OUT_BITS{val[QW-1]}}, val};
      nrm_next[i] = sd_d.degen ? '0 : ext[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sd_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= nrm_next;
      m_tuser <= sd_d.degen;
    end
  end

endmodule

/* sv/tfn_cross.sv */
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, cross product and sign/magnitude split (three stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_cross #(
  parameter int COORD_BITS = 16,
  parameter int EDGE_BITS  = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][COORD_BITS-1:0]          pa,
  input  logic [2:0][COORD_BITS-1:0]          pb,
  input  logic [2:0][COORD_BITS-1:0]          pc,
  output tfn_pkg::tfn_side_t                  side,
  output logic [2:0][2*EDGE_BITS-1:0]         mag
);
  import tfn_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int SH = DW - EDGE_BITS;
  localparam int PW = 2 * EDGE_BITS;

  logic                       v1, v2;
  logic signed [EDGE_BITS-1:0] e1 [3];
  logic signed [EDGE_BITS-1:0] e2 [3];
  logic signed [EDGE_BITS-1:0] e1_next [3];
  logic signed [EDGE_BITS-1:0] e2_next [3];
  logic signed [PW-1:0]        prod [6];
  logic signed [PW-1:0]        prod_next [6];
  logic [2:0][PW-1:0]          mag_next;
  tfn_side_t                   side_next;

  // Stage 1: exact differences, scaled down for very wide coordinates.
  always_comb begin
    logic signed [DW-1:0] d1, d2, s1, s2;
    for (int i = 0; i < 3; i++) begin
      d1 = $signed({pb[i][COORD_BITS-1], pb[i]}) - $signed({pa[i][COORD_BITS-1], pa[i]});
      d2 = $signed({pc[i][COORD_BITS-1], pc[i]}) - $signed({pa[i][COORD_BITS-1], pa[i]});
      s1 = d1 >>> SH;
      s2 = d2 >>> SH;
      e1_next[i] = s1[EDGE_BITS-1:0];
      e2_next[i] = s2[EDGE_BITS-1:0];
    end
  end

  // Stage 2: the six partial products of the cross product.
  always_comb begin
    prod_next[0] = e1[1] * e2[2];
    prod_next[1] = e1[2] * e2[1];
    prod_next[2] = e1[2] * e2[0];
    prod_next[3] = e1[0] * e2[2];
    prod_next[4] = e1[0] * e2[1];
    prod_next[5] = e1[1] * e2[0];
  end

  // Stage 3: differences, then sign and magnitude.
  always_comb begin
    logic signed [PW:0] v;
    side_next = '0;
    side_next.valid = v2;
    for (int i = 0; i < 3; i++) begin
      v = $signed({prod[2*i][PW-1], prod[2*i]}) - $signed({prod[2*i+1][PW-1], prod[2*i+1]});
      side_next.neg[i] = v[PW];
      mag_next[i] = v[PW] ? PW'(-v) : v[PW-1:0];
    end
    side_next.degen = (mag_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      side <= '0;
    end else if (en) begin
      v1   <= in_valid;
      v2   <= v1;
      side <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1   <= e1_next;
      e2   <= e2_next;
      prod <= prod_next;
      mag  <= mag_next;
    end
  end

endmodule

/* sv/tfn_norm.sv */
// ----------------------------------------------------------------------------
// tfn_norm
// Block normalization of the magnitudes and sum of squares (four stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_norm #(
  parameter int MW = 34
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  tfn_pkg::tfn_side_t                    side_in,
  input  logic [2:0][MW-1:0]                    mag_in,
  output tfn_pkg::tfn_side_t                    side_out,
  output logic [tfn_pkg::SUM_BITS-1:0]          sum,
  output logic [2:0][tfn_pkg::MAG_BITS-1:0]     mag_out
);
  import tfn_pkg::*;

  localparam int LW = $clog2(MW);
  localparam int SW = $clog2(MW + 1);
  localparam int XW = MW + MAG_BITS;

  tfn_side_t                  sd_a, sd_b, sd_c;
  logic [2:0][MW-1:0]         mag_a;
  logic [LW-1:0]              lead_a, lead_next;
  logic [2:0][MAG_BITS-1:0]   nm_b, nm_c, nm_next;
  logic [2:0][2*MAG_BITS-1:0] sq_c, sq_next;
  logic [SUM_BITS-1:0]        sum_next;

  // Stage A: position of the leading one of the largest magnitude.
  always_comb begin
    logic [MW-1:0] orw;
    orw = mag_in[0] | mag_in[1] | mag_in[2];
    lead_next = '0;
    for (int i = 0; i < MW; i++) begin
      if (orw[i]) lead_next = LW'(i);
    end
  end

  // Stage B: shift so that the leading one lands at the top bit.
  always_comb begin
    logic [SW-1:0] sa;
    logic [XW-1:0] wide;
    sa = SW'(lead_a) + SW'(1);
    for (int i = 0; i < 3; i++) begin
      wide = {mag_a[i], {MAG_BITS{1'b0}}} >> sa;
      nm_next[i] = wide[MAG_BITS-1:0];
    end
  end

  // Stage C: squares. Stage D: their sum.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_next[i] = (2*MAG_BITS)'(nm_b[i]) * (2*MAG_BITS)'(nm_b[i]);
    end
    sum_next = SUM_BITS'(sq_c[0]) + SUM_BITS'(sq_c[1]) + SUM_BITS'(sq_c[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_a     <= '0;
      sd_b     <= '0;
      sd_c     <= '0;
      side_out <= '0;
    end else if (en) begin
      sd_a     <= side_in;
      sd_b     <= sd_a;
      sd_c     <= sd_b;
      side_out <= sd_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a   <= mag_in;
      lead_a  <= lead_next;
      nm_b    <= nm_next;
      nm_c    <= nm_b;
      sq_c    <= sq_next;
      sum     <= sum_next;
      mag_out <= nm_c;
    end
  end

endmodule

/* sv/tfn_isqrt.sv */
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one result digit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_isqrt #(
  parameter int PW = 95
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [tfn_pkg::SUM_BITS-1:0]     s,
  input  logic [PW-1:0]                    pay_in,
  output logic [tfn_pkg::ROOT_BITS-1:0]    root,
  output logic [PW-1:0]                    pay_out
);
  import tfn_pkg::*;

  localparam int NS = ROOT_BITS + 1;
  localparam int RW = SUM_BITS + 1;
  localparam int TW = SUM_BITS + 2;

  logic [SUM_BITS-1:0] rm  [0:NS];
  logic [RW-1:0]       rs  [0:NS];
  logic [PW-1:0]       pay [0:NS];

  assign rm[0]  = s;
  assign rs[0]  = '0;
  assign pay[0] = pay_in;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [TW-1:0] BIT = TW'(1) << (SUM_BITS - 2*k);
    logic [TW-1:0]       trial;
    logic [SUM_BITS-1:0] rm_next;
    logic [RW-1:0]       rs_next;

    // Subtract the trial square where it fits.
    always_comb begin
      trial = TW'(rs[k]) + BIT;
      if (TW'(rm[k]) >= trial) begin
        rm_next = rm[k] - trial[SUM_BITS-1:0];
        rs_next = (rs[k] >> 1) + BIT[RW-1:0];
      end else begin
        rm_next = rm[k];
        rs_next = rs[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pay[k+1] <= '0;
      end else if (en) begin
        pay[k+1] <= pay[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= rm_next;
        rs[k+1] <= rs_next;
      end
    end
  end

  assign root    = rs[NS][ROOT_BITS-1:0];
  assign pay_out = pay[NS];

endmodule

/* sv/tfn_div.sv */
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined restoring divider for three rounded quotients m * 2^F / len.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_div #(
  parameter int FRAC = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic [tfn_pkg::ROOT_BITS-1:0]          d,
  input  logic [2:0][tfn_pkg::MAG_BITS-1:0]      m,
  input  tfn_pkg::tfn_side_t                     side_in,
  output logic [2:0][FRAC:0]                     q,
  output tfn_pkg::tfn_side_t                     side_out
);
  import tfn_pkg::*;

  localparam int NS = FRAC + 1;
  localparam int NW = MAG_BITS + FRAC + 1;

  logic [2:0][ROOT_BITS-1:0] rm [0:NS];
  logic [2:0][FRAC:0]        lo [0:NS];
  logic [2:0][FRAC:0]        qq [0:NS];
  logic [ROOT_BITS-1:0]      dd [0:NS];
  tfn_side_t                 sd [0:NS];
  logic [2:0][ROOT_BITS-1:0] rm0_next;
  logic [2:0][FRAC:0]        lo0_next;

  // Pre-stage: rounded numerator, split into the top part and the digits.
  always_comb begin
    logic [NW-1:0] n;
    for (int i = 0; i < 3; i++) begin
      n = {1'b0, m[i], {FRAC{1'b0}}} + NW'(d >> 1);
      rm0_next[i] = ROOT_BITS'(n[NW-1:FRAC+1]);
      lo0_next[i] = n[FRAC:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0] <= '0;
    end else if (en) begin
      sd[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= rm0_next;
      lo[0] <= lo0_next;
      qq[0] <= '0;
      dd[0] <= d;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [2:0][ROOT_BITS-1:0] rm_next;
    logic [2:0][FRAC:0]        qq_next;

    // One quotient bit for each component.
    always_comb begin
      logic [ROOT_BITS:0] r;
      for (int i = 0; i < 3; i++) begin
        r = {rm[j][i], lo[j][i][FRAC-j]};
        if (r >= {1'b0, dd[j]}) begin
          rm_next[i] = ROOT_BITS'(r - {1'b0, dd[j]});
          qq_next[i] = {qq[j][i][FRAC-1:0], 1'b1};
        end else begin
          rm_next[i] = r[ROOT_BITS-1:0];
          qq_next[i] = {qq[j][i][FRAC-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[j+1] <= '0;
      end else if (en) begin
        sd[j+1] <= sd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[j+1] <= rm_next;
        lo[j+1] <= lo[j];
        qq[j+1] <= qq_next;
        dd[j+1] <= dd[j];
      end
    end
  end

  assign q        = qq[NS];
  assign side_out = sd[NS];

endmodule

/* sv/tfn_checker.sv */
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks of the triangle face normal core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_face_normal_core_defines.svh"

module tfn_checker #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic [((9*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [3*tfn_pkg::OUT_BITS-1:0]        m_tdata,
  input logic                                  m_tuser,
  input logic                                  m_tvalid,
  input logic                                  m_tready
);

  // A stalled result keeps its payload.
  `TFN_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  // The input side is open exactly when the output register can move.
  `TFN_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready), "input ready does not follow the output side")
  // A degenerate triangle reports a zero normal.
  `TFN_ASSERT(a_degen, m_tvalid && m_tuser |-> m_tdata == '0, "degenerate result with nonzero normal")
  // No result is valid in the cycle after a reset cycle.
  `TFN_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind triangle_face_normal_core tfn_checker #(
  .COORD_BITS(COORD_BITS),
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tfn_checker (.*);
